// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/spfd_pkg.sv =====
// ----------------------------------------------------------------------------
// spfd_pkg
// Types and constants of the sensor packet framer and deframer.
// ----------------------------------------------------------------------------
package spfd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } rx_phase_e;

  typedef enum logic [1:0] {
    EV_CONFIRM = 2'd0,
    EV_DATA    = 2'd1,
    EV_END     = 2'd2,
    EV_LEN_ERR = 2'd3
  } rx_event_e;

  localparam logic [7:0] SyncHi   = 8'hEF;
  localparam logic [7:0] SyncLo   = 8'h01;
  localparam logic [7:0] AddrByte = 8'hFF;
  localparam logic [7:0] PidCmd   = 8'h01;

  localparam int unsigned OutMax     = 10;
  localparam int unsigned FrameWorst = 12;
  localparam int unsigned ModelDepth = 64;
  localparam int unsigned HdrBytes   = 9;
  localparam int unsigned TxqDepth   = 64;
  localparam int unsigned EvqDepth   = 4;
  localparam int unsigned PosW       = 10;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [3:0]      slot_t;

  localparam slot_t SlotLenHi = 4'd7;
  localparam slot_t SlotLen   = 4'd8;
  localparam slot_t SlotData  = 4'd9;
  localparam slot_t SlotSumHi = 4'd10;
  localparam slot_t SlotSumLo = 4'd11;

  typedef struct packed {
    logic        start;
    logic        fin;
    logic [7:0]  len;
    logic [7:0]  data;
    logic [15:0] sum;
  } tx_entry_t;

  typedef struct packed {
    rx_event_e  ev;
    logic [7:0] val;
    pos_t       pos;
  } rx_token_t;

  typedef struct packed {
    logic      valid;
    tx_entry_t entry;
  } tx_push_t;

  typedef struct packed {
    logic      valid;
    rx_token_t token;
  } rx_push_t;

  function automatic logic [7:0] frame_byte(input slot_t k, input tx_entry_t e);
    logic [7:0] b;
    case (k)
      4'd0:      b = SyncHi;
      4'd1:      b = SyncLo;
      4'd2:      b = AddrByte;
      4'd3:      b = AddrByte;
      4'd4:      b = AddrByte;
      4'd5:      b = AddrByte;
      4'd6:      b = PidCmd;
      SlotLenHi: b = 8'h00;
      SlotLen:   b = e.len;
      SlotData:  b = e.data;
      SlotSumHi: b = e.sum[15:8];
      SlotSumLo: b = e.sum[7:0];
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/spfd_front.sv =====
// ----------------------------------------------------------------------------
// spfd_front
// Accepts input words, runs frame and sync state, tracks transmit release.
// ----------------------------------------------------------------------------
module spfd_front #(
  parameter int unsigned MAX_REPLY_DATA  = 32,
  parameter int unsigned MAX_CMD_PAYLOAD = 53
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         data_byte_i,
  input  logic [5:0]         payload_len_i,
  input  logic               txq_full_i,
  input  logic               evq_full_i,
  output spfd_pkg::tx_push_t tx_push_o,
  output spfd_pkg::rx_push_t rx_push_o,
  output spfd_pkg::pos_t     rel_pos_o
);
  import spfd_pkg::*;

  localparam int unsigned BodyW     = $clog2(MAX_REPLY_DATA + 4);
  localparam logic [6:0]  DropAbove = 7'(ModelDepth - FrameWorst);
  localparam logic [15:0] LenMax    = 16'(MAX_REPLY_DATA + 3);

  rx_phase_e        phase_q, phase_d;
  logic [7:0]       prev_q, prev_d;
  logic [2:0]       hc_q, hc_d;
  logic [15:0]      rlen_q, rlen_d;
  logic [BodyW-1:0] body_q, body_d;
  logic [5:0]       rem_q, rem_d;
  logic [15:0]      sum_q, sum_d;
  logic [6:0]       vq_q, vq_d;
  pos_t             rel_q, rel_d;

  logic        acc;
  logic        drop, start, fin;
  logic [5:0]  n_len, rem_cur;
  logic [7:0]  len8;
  logic [15:0] sum_base, sum_new;
  logic [3:0]  push_n;
  logic        ev_v;
  rx_event_e   ev;
  logic [7:0]  ev_val;
  logic [15:0] rlen_nx;
  logic [6:0]  fill, lim, drain;

  assign in_ready_o = !txq_full_i && !evq_full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    drop = vq_q > DropAbove;
    start = rem_q == 6'd0;
    if (payload_len_i == 6'd0) begin
      n_len = 6'd1;
    end else if ({2'b00, payload_len_i} > 8'(MAX_CMD_PAYLOAD)) begin
      n_len = 6'(MAX_CMD_PAYLOAD);
    end else begin
      n_len = payload_len_i;
    end
    len8     = {2'b00, n_len} + 8'd2;
    sum_base = start ? 16'd1 + {8'h00, len8} : sum_q;
    sum_new  = sum_base + {8'h00, data_byte_i};
    rem_cur  = start ? n_len : rem_q;
    fin      = (rem_cur - 6'd1) == 6'd0;
    push_n   = 4'd0;
    rem_d    = rem_q;
    sum_d    = sum_q;
    if (!kind_i && !drop) begin
      push_n = (start ? 4'(HdrBytes) : 4'd0) + 4'd1 + (fin ? 4'd2 : 4'd0);
      rem_d  = rem_cur - 6'd1;
      sum_d  = sum_new;
    end
  end

  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    hc_d    = hc_q;
    rlen_d  = rlen_q;
    body_d  = body_q;
    ev_v    = 1'b0;
    ev      = EV_CONFIRM;
    ev_val  = 8'h00;
    rlen_nx = rlen_q;
    if (hc_q == 3'd5) begin
      rlen_nx = {data_byte_i, rlen_q[7:0]};
    end else if (hc_q == 3'd6) begin
      rlen_nx = {rlen_q[15:8], data_byte_i};
    end
    if (kind_i) begin
      case (phase_q)
        PH_HEAD: begin
          rlen_d = rlen_nx;
          if (hc_q == 3'd6) begin
            hc_d = 3'd0;
            if (rlen_nx < 16'd3 || rlen_nx > LenMax) begin
              phase_d = PH_HUNT;
              prev_d  = 8'h00;
              ev_v    = 1'b1;
              ev      = EV_LEN_ERR;
            end else begin
              phase_d = PH_BODY;
              body_d  = '0;
            end
          end else begin
            hc_d = hc_q + 3'd1;
          end
        end
        PH_BODY: begin
          body_d = body_q + BodyW'(1);
          if (body_q == '0) begin
            ev_v   = 1'b1;
            ev     = EV_CONFIRM;
            ev_val = data_byte_i;
          end else if (17'(body_q) + 17'd3 <= {1'b0, rlen_q}) begin
            ev_v   = 1'b1;
            ev     = EV_DATA;
            ev_val = data_byte_i;
          end else if (17'(body_q) + 17'd1 >= {1'b0, rlen_q}) begin
            phase_d = PH_HUNT;
            prev_d  = 8'h00;
            body_d  = '0;
            ev_v    = 1'b1;
            ev      = EV_END;
          end
        end
        default: begin
          if (prev_q == SyncHi && data_byte_i == SyncLo) begin
            phase_d = PH_HEAD;
            hc_d    = 3'd0;
            rlen_d  = 16'h0000;
          end else begin
            phase_d = PH_HUNT;
          end
          prev_d = data_byte_i;
        end
      endcase
    end
  end

  always_comb begin
    fill  = vq_q + {3'b000, push_n};
    lim   = ev_v ? 7'(OutMax - 1) : 7'(OutMax);
    drain = (fill < lim) ? fill : lim;
    vq_d  = fill - drain;
    rel_d = rel_q + pos_t'(drain);
  end

  assign tx_push_o.valid       = acc && !kind_i && !drop;
  assign tx_push_o.entry.start = start;
  assign tx_push_o.entry.fin   = fin;
  assign tx_push_o.entry.len   = len8;
  assign tx_push_o.entry.data  = data_byte_i;
  assign tx_push_o.entry.sum   = sum_new;

  assign rx_push_o.valid     = acc && ev_v;
  assign rx_push_o.token.ev  = ev;
  assign rx_push_o.token.val = ev_val;
  assign rx_push_o.token.pos = rel_d;

  assign rel_pos_o = rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      prev_q  <= 8'h00;
      hc_q    <= 3'd0;
      rlen_q  <= 16'h0000;
      body_q  <= '0;
      rem_q   <= 6'd0;
      sum_q   <= 16'h0000;
      vq_q    <= 7'd0;
      rel_q   <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      hc_q    <= hc_d;
      rlen_q  <= rlen_d;
      body_q  <= body_d;
      rem_q   <= rem_d;
      sum_q   <= sum_d;
      vq_q    <= vq_d;
      rel_q   <= rel_d;
    end
  end

endmodule

// ===== hw/rtl/spfd_txq.sv =====
// ----------------------------------------------------------------------------
// spfd_txq
// Transmit entry queue: memory with a registered head word.
// ----------------------------------------------------------------------------
module spfd_txq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spfd_pkg::tx_push_t  push_i,
  output logic                full_o,
  output logic                head_valid_o,
  output spfd_pkg::tx_entry_t head_o,
  input  logic                pop_i
);
  import spfd_pkg::*;

  localparam int unsigned AW = $clog2(TxqDepth);
  localparam int unsigned CW = $clog2(TxqDepth + 1);

  tx_entry_t mem [TxqDepth];
  tx_entry_t head_q;
  logic      head_v_q;
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic      fill, take, bypass, wr_en;

  assign fill   = !head_v_q || pop_i;
  assign take   = fill && (cnt_q != '0);
  assign bypass = fill && (cnt_q == '0) && push_i.valid;
  assign wr_en  = push_i.valid && !bypass;

  assign full_o       = cnt_q == CW'(TxqDepth);
  assign head_valid_o = head_v_q;
  assign head_o       = head_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_q] <= push_i.entry;
    end
    if (take) begin
      head_q <= mem[rd_q];
    end else if (bypass) begin
      head_q <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
    end else begin
      if (fill) begin
        head_v_q <= take || bypass;
      end
      if (wr_en) begin
        wr_q <= wr_q + AW'(1);
      end
      if (take) begin
        rd_q <= rd_q + AW'(1);
      end
      cnt_q <= cnt_q + CW'(wr_en) - CW'(take);
    end
  end

endmodule

// ===== hw/rtl/spfd_evq.sv =====
// ----------------------------------------------------------------------------
// spfd_evq
// Receive event queue, each event tagged with its transmit release point.
// ----------------------------------------------------------------------------
module spfd_evq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spfd_pkg::rx_push_t  push_i,
  output logic                full_o,
  output logic                head_valid_o,
  output spfd_pkg::rx_token_t head_o,
  input  logic                pop_i
);
  import spfd_pkg::*;

  localparam int unsigned AW = $clog2(EvqDepth);
  localparam int unsigned CW = $clog2(EvqDepth + 1);

  rx_token_t     slot_q [EvqDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          wr_en, rd_en;

  assign full_o       = cnt_q == CW'(EvqDepth);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = slot_q[rd_q];
  assign wr_en        = push_i.valid && !full_o;
  assign rd_en        = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_q] <= push_i.token;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= wr_q + AW'(1);
      end
      if (rd_en) begin
        rd_q <= rd_q + AW'(1);
      end
      cnt_q <= cnt_q + CW'(wr_en) - CW'(rd_en);
    end
  end

endmodule

// ===== hw/rtl/spfd_back.sv =====
// ----------------------------------------------------------------------------
// spfd_back
// Expands queued entries into framed bytes, merges events, drives output.
// ----------------------------------------------------------------------------
module spfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tx_valid_i,
  input  spfd_pkg::tx_entry_t tx_head_i,
  output logic                tx_pop_o,
  input  logic                ev_valid_i,
  input  spfd_pkg::rx_token_t ev_head_i,
  output logic                ev_pop_o,
  input  spfd_pkg::pos_t      rel_pos_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                direction_o,
  output logic [7:0]          tx_byte_o,
  output logic [1:0]          rx_event_o,
  output logic [7:0]          rx_value_o,
  output logic                last_o
);
  import spfd_pkg::*;

  slot_t      ph_q, ph_d;
  pos_t       pos_q, pos_d;
  logic       out_v_q, out_v_d;
  logic       dir_q, dir_d;
  logic [7:0] txb_q, txb_d;
  logic [1:0] ev_q, ev_d;
  logic [7:0] val_q, val_d;
  logic       last_q, last_d;

  logic       load, ev_go, tx_go, ent_done;
  slot_t      k;

  assign load  = !out_v_q || out_ready_i;
  assign ev_go = ev_valid_i && (ev_head_i.pos == pos_q);
  assign tx_go = !ev_go && tx_valid_i && (pos_q != rel_pos_i);
  assign k     = tx_head_i.start ? ph_q : ph_q + SlotData;
  assign ent_done = (k == SlotData && !tx_head_i.fin) || k == SlotSumLo;

  assign ev_pop_o = load && ev_go;
  assign tx_pop_o = load && tx_go && ent_done;

  always_comb begin
    ph_d    = ph_q;
    pos_d   = pos_q;
    out_v_d = out_v_q;
    dir_d   = dir_q;
    txb_d   = txb_q;
    ev_d    = ev_q;
    val_d   = val_q;
    last_d  = last_q;
    if (load) begin
      out_v_d = ev_go || tx_go;
      if (ev_go) begin
        dir_d  = 1'b1;
        txb_d  = 8'h00;
        ev_d   = ev_head_i.ev;
        val_d  = ev_head_i.val;
        last_d = ev_head_i.ev == EV_END || ev_head_i.ev == EV_LEN_ERR;
      end else if (tx_go) begin
        dir_d  = 1'b0;
        txb_d  = frame_byte(k, tx_head_i);
        ev_d   = EV_CONFIRM;
        val_d  = 8'h00;
        last_d = k == SlotSumLo;
        ph_d   = ent_done ? 4'd0 : ph_q + 4'd1;
        pos_d  = pos_q + pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= 4'd0;
      pos_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      pos_q   <= pos_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    txb_q  <= txb_d;
    ev_q   <= ev_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_v_q;
  assign direction_o = dir_q;
  assign tx_byte_o   = txb_q;
  assign rx_event_o  = ev_q;
  assign rx_value_o  = val_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/sensor_packet_framer_deframer.sv =====
// ----------------------------------------------------------------------------
// sensor_packet_framer_deframer
// Command framer and reply deframer for a serial sensor packet protocol.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                | payload
//  in      | in  | in_valid_i / in_ready_o  | kind, data_byte, payload_len
//  out     | out | out_valid_o / out_ready_i| direction, tx_byte, rx_event,
//          |     |                          | rx_value, last
//
// One input word is taken per cycle while the 64-entry transmit queue and the
// 4-entry event queue have room. The output register moves one word per cycle
// while out_ready_i is high; the first byte of a frame expands to 10 output
// words, 12 when it also ends the frame, later bytes to 1 or 3, received bytes
// to at most 1. Reset is immediate; no memory clearing pass.
// ----------------------------------------------------------------------------
module sensor_packet_framer_deframer #(
  parameter int unsigned MAX_REPLY_DATA  = 32,
  parameter int unsigned MAX_CMD_PAYLOAD = 53
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  input  logic [5:0] payload_len_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       direction_o,
  output logic [7:0] tx_byte_o,
  output logic [1:0] rx_event_o,
  output logic [7:0] rx_value_o,
  output logic       last_o
);
  import spfd_pkg::*;

  tx_push_t  tx_push;
  rx_push_t  rx_push;
  pos_t      rel_pos;
  logic      txq_full, evq_full;
  logic      tx_valid, tx_pop, ev_valid, ev_pop;
  tx_entry_t tx_head;
  rx_token_t ev_head;

  spfd_front #(
    .MAX_REPLY_DATA (MAX_REPLY_DATA),
    .MAX_CMD_PAYLOAD(MAX_CMD_PAYLOAD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .payload_len_i(payload_len_i),
    .txq_full_i   (txq_full),
    .evq_full_i   (evq_full),
    .tx_push_o    (tx_push),
    .rx_push_o    (rx_push),
    .rel_pos_o    (rel_pos)
  );

  spfd_txq u_txq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tx_push),
    .full_o      (txq_full),
    .head_valid_o(tx_valid),
    .head_o      (tx_head),
    .pop_i       (tx_pop)
  );

  spfd_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rx_push),
    .full_o      (evq_full),
    .head_valid_o(ev_valid),
    .head_o      (ev_head),
    .pop_i       (ev_pop)
  );

  spfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tx_valid_i (tx_valid),
    .tx_head_i  (tx_head),
    .tx_pop_o   (tx_pop),
    .ev_valid_i (ev_valid),
    .ev_head_i  (ev_head),
    .ev_pop_o   (ev_pop),
    .rel_pos_i  (rel_pos),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .direction_o(direction_o),
    .tx_byte_o  (tx_byte_o),
    .rx_event_o (rx_event_o),
    .rx_value_o (rx_value_o),
    .last_o     (last_o)
  );

endmodule

// ===== hw/rtl/spfd_checker.sv =====
// ----------------------------------------------------------------------------
// spfd_checker
// Port-level checks of the framer and deframer output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       direction_o,
  input logic [7:0] tx_byte_o,
  input logic [1:0] rx_event_o,
  input logic [7:0] rx_value_o,
  input logic       last_o
);
  import spfd_pkg::*;

  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o) && $stable(rx_event_o), "output word dropped")

  `ASSERT_CLK(a_tx_clean, clk_i, rst_ni, out_valid_o && !direction_o |-> rx_event_o == EV_CONFIRM && rx_value_o == 8'h00, "tx word carries event fields")

  `ASSERT_CLK(a_ev_last, clk_i, rst_ni, out_valid_o && direction_o |-> tx_byte_o == 8'h00 && (last_o == (rx_event_o == EV_END || rx_event_o == EV_LEN_ERR)), "event last flag wrong")

  `ASSERT_CLK(a_end_value, clk_i, rst_ni, out_valid_o && direction_o && last_o |-> rx_value_o == 8'h00, "end event carries value")

endmodule

bind sensor_packet_framer_deframer spfd_checker u_spfd_checker (.*);

// ===== tb/sv/tb_sensor_packet_framer_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_packet_framer_deframer
// Self-checking bench for the sensor packet framer and deframer. A short table
// of command and reply bytes covers the length extremes, a bad reply length
// and a complete reply. Random command frames, queue-filling bursts, replies
// and noise follow. Every output word is checked in order against a local
// model of the framer, the deframer and the output ordering of the block.
// ----------------------------------------------------------------------------
module tb_sensor_packet_framer_deframer;
  import spfd_pkg::*;

  localparam int unsigned MAX_REPLY_DATA  = 32;
  localparam int unsigned MAX_CMD_PAYLOAD = 53;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [5:0] plen;
    logic       typed;
    rx_event_e  ev;
    logic [7:0] val;
  } in_word_t;

  typedef struct packed {
    logic       direction;
    logic [7:0] tx_byte;
    rx_event_e  rx_event;
    logic [7:0] rx_value;
    logic       last;
  } out_word_t;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_PATTERN
  } sink_mode_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b1;
  logic     in_valid  = 1'b0;
  logic     out_ready = 1'b0;
  in_word_t cur_in    = '0;

  logic       in_ready;
  logic       out_valid;
  logic       direction;
  logic [7:0] tx_byte;
  logic [1:0] rx_event;
  logic [7:0] rx_value;
  logic       last;

  rx_phase_e   rx_phase   = PH_HUNT;
  logic [7:0]  prev_rx    = 8'h00;
  logic [2:0]  hdr_cnt    = 3'd0;
  logic [15:0] reply_len  = 16'd0;
  logic [15:0] body_cnt   = 16'd0;
  logic [5:0]  tx_left    = 6'd0;
  logic [15:0] tx_sum     = 16'd0;
  logic [8:0]  framed_backlog[$];
  out_word_t   frame_words_due[$];

  int         errors      = 0;
  int         taken_words = 0;
  int         burst_left  = 0;
  int         mode_left   = 0;
  sink_mode_e sink_mode   = SINK_ALWAYS;
  logic [7:0] stall_mask  = 8'hFF;

  sensor_packet_framer_deframer #(
    .MAX_REPLY_DATA (MAX_REPLY_DATA),
    .MAX_CMD_PAYLOAD(MAX_CMD_PAYLOAD)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (cur_in.kind),
    .data_byte_i  (cur_in.data),
    .payload_len_i(cur_in.plen),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .direction_o  (direction),
    .tx_byte_o    (tx_byte),
    .rx_event_o   (rx_event),
    .rx_value_o   (rx_value),
    .last_o       (last)
  );

  always #5 clk = ~clk;

  function automatic out_word_t rx_word(input rx_event_e ev, input logic [7:0] val);
    out_word_t w;
    w.direction = 1'b1;
    w.tx_byte   = 8'h00;
    w.rx_event  = ev;
    w.rx_value  = val;
    w.last      = (ev == EV_END) || (ev == EV_LEN_ERR);
    return w;
  endfunction

  function automatic in_word_t stim_word(input logic kind, input logic [7:0] data,
                                         input logic [5:0] plen);
    in_word_t w;
    w       = '0;
    w.kind  = kind;
    w.data  = data;
    w.plen  = plen;
    w.ev    = EV_CONFIRM;
    return w;
  endfunction

  function automatic string word_text(input out_word_t w);
    return $sformatf("dir=%0d tx=%02h ev=%0d val=%02h last=%0d",
                     w.direction, w.tx_byte, w.rx_event, w.rx_value, w.last);
  endfunction

  task automatic predict_frame_words(input in_word_t w, output bit dropped);
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] idx;
    logic [8:0]  e;
    bit          has_ev;
    out_word_t   ev_word;
    int          n;
    int          k;
    b       = w.data;
    dropped = 1'b0;
    has_ev  = 1'b0;
    ev_word = '0;
    if (w.kind == 1'b0) begin
      if (framed_backlog.size() > ModelDepth - FrameWorst) begin
        dropped = 1'b1;
      end else begin
        if (tx_left == 6'd0) begin
          n = (w.plen == 6'd0) ? 1 : int'(w.plen);
          if (n > MAX_CMD_PAYLOAD) n = MAX_CMD_PAYLOAD;
          len = 16'(n + 2);
          framed_backlog.push_back({1'b0, SyncHi});
          framed_backlog.push_back({1'b0, SyncLo});
          repeat (4) framed_backlog.push_back({1'b0, AddrByte});
          framed_backlog.push_back({1'b0, PidCmd});
          framed_backlog.push_back({1'b0, len[15:8]});
          framed_backlog.push_back({1'b0, len[7:0]});
          tx_sum  = 16'd1 + 16'(len[15:8]) + 16'(len[7:0]);
          tx_left = 6'(n);
        end
        framed_backlog.push_back({1'b0, b});
        tx_sum  = tx_sum + 16'(b);
        tx_left = tx_left - 6'd1;
        if (tx_left == 6'd0) begin
          framed_backlog.push_back({1'b0, tx_sum[15:8]});
          framed_backlog.push_back({1'b1, tx_sum[7:0]});
        end
      end
    end else begin
      case (rx_phase)
        PH_HEAD: begin
          if (hdr_cnt == 3'd5) reply_len[15:8] = b;
          else if (hdr_cnt == 3'd6) reply_len[7:0] = b;
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt >= 3'd7) begin
            hdr_cnt = 3'd0;
            if (reply_len < 16'd3 || int'(reply_len) > MAX_REPLY_DATA + 3) begin
              rx_phase = PH_HUNT;
              prev_rx  = 8'h00;
              has_ev   = 1'b1;
              ev_word  = rx_word(EV_LEN_ERR, 8'h00);
            end else begin
              rx_phase = PH_BODY;
              body_cnt = 16'd0;
            end
          end
        end
        PH_BODY: begin
          idx      = body_cnt;
          body_cnt = body_cnt + 16'd1;
          if (idx == 16'd0) begin
            has_ev  = 1'b1;
            ev_word = rx_word(EV_CONFIRM, b);
          end else if (int'(idx) + 3 <= int'(reply_len)) begin
            has_ev  = 1'b1;
            ev_word = rx_word(EV_DATA, b);
          end else if (int'(idx) + 1 >= int'(reply_len)) begin
            rx_phase = PH_HUNT;
            prev_rx  = 8'h00;
            body_cnt = 16'd0;
            has_ev   = 1'b1;
            ev_word  = rx_word(EV_END, 8'h00);
          end
        end
        default: begin
          if (prev_rx == SyncHi && b == SyncLo) begin
            rx_phase  = PH_HEAD;
            hdr_cnt   = 3'd0;
            reply_len = 16'd0;
          end else begin
            rx_phase = PH_HUNT;
          end
          prev_rx = b;
        end
      endcase
    end
    if (w.typed) begin
      has_ev  = 1'b1;
      ev_word = rx_word(w.ev, w.val);
    end
    k = 0;
    while (framed_backlog.size() > 0 && k < int'(OutMax) - int'(has_ev)) begin
      e = framed_backlog.pop_front();
      frame_words_due.push_back({1'b0, e[7:0], EV_CONFIRM, 8'h00, e[8]});
      k++;
    end
    if (has_ev) frame_words_due.push_back(ev_word);
  endtask

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    bit        dropped;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_frame_words(cur_in, dropped);
        if (!dropped) taken_words++;
      end
      if (out_valid && out_ready) begin
        got.direction = direction;
        got.tx_byte   = tx_byte;
        got.rx_event  = rx_event_e'(rx_event);
        got.rx_value  = rx_value;
        got.last      = last;
        if (frame_words_due.size() == 0) begin
          if (errors < 50) $display("%0t unexpected word: expected none, actual %s",
                                    $time, word_text(got));
          errors++;
        end else begin
          want = frame_words_due.pop_front();
          if (got !== want) begin
            if (errors < 50) $display("%0t mismatch: expected %s, actual %s",
                                      $time, word_text(want), word_text(got));
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left  = $urandom_range(16, 160);
      sink_mode  = sink_mode_e'($urandom_range(0, 2));
      stall_mask = 8'($urandom) | 8'h01;
    end
    mode_left--;
    stall_mask = {stall_mask[6:0], stall_mask[7]};
    case (sink_mode)
      SINK_ALWAYS: out_ready <= 1'b1;
      SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
      default:     out_ready <= stall_mask[0];
    endcase
  end

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cur_in   <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (frame_words_due.size() != 0);
  endtask

  initial begin
    in_word_t   script[0:22];
    in_word_t   cmd_plan[$];
    in_word_t   reply_plan[$];
    int         target;
    int         stick_cmd;
    int         sel;
    int         n;
    int         plen;
    bit         pressed;
    bit         use_cmd;
    logic [7:0] len_hi;
    logic [7:0] len_lo;

    rst_n <= 1'b0;
    script = '{
      '{1'b0, 8'h00, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b0, 8'hFF, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hEF, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h01, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h01, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h00, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h24, 6'd0,  1'b1, EV_LEN_ERR, 8'h00},
      '{1'b1, 8'hEF, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h01, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hFF, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h07, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h00, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h03, 6'd63, 1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'h5A, 6'd0,  1'b1, EV_CONFIRM, 8'h5A},
      '{1'b1, 8'hC3, 6'd0,  1'b0, EV_CONFIRM, 8'h00},
      '{1'b1, 8'hD4, 6'd0,  1'b1, EV_END,     8'h00}
    };
    stick_cmd = 0;
    pressed   = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) send_word(script[i]);
    wait_drained();

    target = taken_words + 300;
    while (taken_words < target) begin
      if (!pressed && taken_words >= target - 150) begin
        wait_drained();
        pressed = 1'b1;
      end
      if (stick_cmd > 0) begin
        use_cmd = 1'b1;
        stick_cmd--;
      end else begin
        use_cmd = ($urandom_range(0, 2) == 0);
      end

      if (use_cmd && cmd_plan.size() == 0) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          case ($urandom_range(0, 9))
            0:       plen = 0;
            1:       plen = $urandom_range(MAX_CMD_PAYLOAD, 63);
            2:       plen = $urandom_range(7, MAX_CMD_PAYLOAD - 1);
            default: plen = $urandom_range(1, 6);
          endcase
          n = (plen == 0) ? 1 : ((plen > MAX_CMD_PAYLOAD) ? MAX_CMD_PAYLOAD : plen);
          cmd_plan.push_back(stim_word(1'b0, 8'($urandom), 6'(plen)));
          repeat (n - 1) cmd_plan.push_back(stim_word(1'b0, 8'($urandom), 6'($urandom)));
        end else if (sel < 8) begin
          repeat (30) cmd_plan.push_back(stim_word(1'b0, 8'($urandom), 6'd1));
          stick_cmd = 30;
        end else begin
          repeat ($urandom_range(1, 3))
            cmd_plan.push_back(stim_word(1'b0, 8'($urandom), 6'($urandom)));
        end
      end

      if (!use_cmd && reply_plan.size() == 0) begin
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
          reply_plan.push_back(stim_word(1'b1, SyncHi, 6'($urandom)));
          reply_plan.push_back(stim_word(1'b1, SyncLo, 6'($urandom)));
          repeat (4)
            reply_plan.push_back(stim_word(1'b1,
              ($urandom_range(0, 9) == 0) ? 8'($urandom) : AddrByte, 6'($urandom)));
          reply_plan.push_back(stim_word(1'b1, 8'($urandom), 6'($urandom)));
          if (sel < 6) begin
            case ($urandom_range(0, 5))
              0:       n = 3;
              1:       n = MAX_REPLY_DATA + 3;
              default: n = $urandom_range(3, MAX_REPLY_DATA + 3);
            endcase
            len_hi = 8'h00;
            len_lo = 8'(n);
          end else begin
            case ($urandom_range(0, 2))
              0: begin
                len_hi = 8'h00;
                len_lo = 8'($urandom_range(0, 2));
              end
              1: begin
                len_hi = 8'h00;
                len_lo = 8'($urandom_range(MAX_REPLY_DATA + 4, 255));
              end
              default: begin
                len_hi = 8'($urandom_range(1, 255));
                len_lo = 8'($urandom);
              end
            endcase
            n = 0;
          end
          reply_plan.push_back(stim_word(1'b1, len_hi, 6'($urandom)));
          reply_plan.push_back(stim_word(1'b1, len_lo, 6'($urandom)));
          repeat (n) reply_plan.push_back(stim_word(1'b1, 8'($urandom), 6'($urandom)));
        end else begin
          repeat ($urandom_range(1, 6))
            reply_plan.push_back(stim_word(1'b1,
              ($urandom_range(0, 3) == 0) ? SyncHi : 8'($urandom), 6'($urandom)));
        end
      end

      send_word(use_cmd ? cmd_plan.pop_front() : reply_plan.pop_front());
    end

    wait_drained();
    repeat (64) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
